@@ hw/rtl/ptpm_pkg.sv @@
// Shared constants, types and helper functions of the peak timing phase meter.
`timescale 1ns / 1ps

package ptpm_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int TICKS_W     = 24;
   localparam int PHASE_W     = 10;
   localparam int LEVEL_W     = 8;
   localparam int GAIN_W      = 12;
   localparam int ERR_W       = 2;

   localparam int DEG_FULL    = 360;
   localparam int DEG_W       = 9;
   localparam int DIV_W       = COUNT_WIDTH + DEG_W;
   localparam int STEP_W      = $clog2(DIV_W);
   localparam int GAIN_SHIFT  = 10;
   localparam int BASE_W      = 21;
   localparam int BASE_LIMIT  = 1 << (BASE_W - 1);
   localparam int PROD_W      = BASE_W + GAIN_W;
   localparam int PHASE_MAX   = 1023;
   localparam int TICKS_MAX   = (1 << TICKS_W) - 1;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_SEL_BIT = 2;

   localparam logic REG_PEAK_LEVEL = 1'b0;
   localparam logic REG_GAIN       = 1'b1;

   localparam logic [LEVEL_W-1:0] PEAK_LEVEL_RESET = 8'd255;
   localparam logic [GAIN_W-1:0]  GAIN_RESET       = 12'd1055;

   localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
   localparam logic [ERR_W-1:0] ERR_PERIOD_ZERO = 2'd1;
   localparam logic [ERR_W-1:0] ERR_SATURATED   = 2'd2;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_REARM = 1'b1;

   typedef struct packed {
      logic rearm;
      logic first_peak;
      logic count;
      logic latch_period;
      logic launch;
      logic div_step;
      logic multiply;
      logic load_out;
   } ptpm_cmd_type;

   typedef struct packed {
      logic ref_peak;
      logic tst_peak;
      logic div_last;
      logic out_free;
   } ptpm_status_type;

   function automatic logic [TICKS_W-1:0] clip_ticks(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'(TICKS_MAX)) ? TICKS_W'(TICKS_MAX) : w[TICKS_W-1:0];
   endfunction

endpackage

@@ hw/rtl/ptpm_if.sv @@
// Beat channel interfaces for the request and response sides of the phase meter.
`timescale 1ns / 1ps

interface ptpm_req_if;
   import ptpm_pkg::*;
   logic               valid;
   logic               ready;
   logic               command;
   logic [LEVEL_W-1:0] sample_ref;
   logic [LEVEL_W-1:0] sample_test;

   modport source (output valid, command, sample_ref, sample_test, input ready);
   modport sink (input valid, command, sample_ref, sample_test, output ready);
endinterface

interface ptpm_rsp_if;
   import ptpm_pkg::*;
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase_degrees;
   logic [TICKS_W-1:0] period_ticks;
   logic [TICKS_W-1:0] delay_ticks;
   logic [ERR_W-1:0]   error_code;

   modport source (output valid, phase_degrees, period_ticks, delay_ticks, error_code,
                   input ready);
   modport sink (input valid, phase_degrees, period_ticks, delay_ticks, error_code,
                 output ready);
endinterface

@@ hw/rtl/peak_timing_phase_meter_top.sv @@
// Top level of the peak timing phase meter: request and response channels plus registers.
`timescale 1ns / 1ps

// The meter takes one tick beat per clock cycle while it measures: it waits for a
// reference peak, times the reference period to the next peak and then the delay to
// the first test peak. A rearm beat restarts it from any measuring or idle state.
// When the test peak arrives it computes the phase with a restoring divider that
// retires one quotient bit per cycle, so the request side is held off for the 33
// divider steps, one multiply by the gain and the load of the response register,
// and for as long as the response register is still occupied. The response register
// lets the next tick be accepted while the finished result waits to be taken; ticks
// after a result are ignored until a rearm beat.

module peak_timing_phase_meter_top
   import ptpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ptpm_req_if.sink              req_bus,
   ptpm_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LEVEL_W-1:0] peak_level;
   logic [GAIN_W-1:0]  correction_gain;
   ptpm_cmd_type       cmd;
   ptpm_status_type    status;

   ptpm_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .peak_level      (peak_level),
      .correction_gain (correction_gain)
   );

   ptpm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   ptpm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .sample_ref      (req_bus.sample_ref),
      .sample_test     (req_bus.sample_test),
      .peak_level      (peak_level),
      .correction_gain (correction_gain),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .phase_degrees   (rsp_bus.phase_degrees),
      .period_ticks    (rsp_bus.period_ticks),
      .delay_ticks     (rsp_bus.delay_ticks),
      .error_code      (rsp_bus.error_code)
   );

endmodule

@@ hw/rtl/ptpm_csr.sv @@
// APB-style configuration registers holding the peak level and the correction gain.
`timescale 1ns / 1ps

module ptpm_csr
   import ptpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [LEVEL_W-1:0]    peak_level,
   output logic [GAIN_W-1:0]     correction_gain
);

   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic               wr_en;
   logic               reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[CSR_SEL_BIT];

   always_comb begin
      level_in = level_ff;
      gain_in  = gain_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_PEAK_LEVEL: level_in = pwdata[LEVEL_W-1:0];
            REG_GAIN:       gain_in  = pwdata[GAIN_W-1:0];
            default:        level_in = level_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_PEAK_LEVEL: prdata = CSR_DATA_W'(level_ff);
         REG_GAIN:       prdata = CSR_DATA_W'(gain_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= PEAK_LEVEL_RESET;
         gain_ff  <= GAIN_RESET;
      end else begin
         level_ff <= level_in;
         gain_ff  <= gain_in;
      end
   end

   assign peak_level      = level_ff;
   assign correction_gain = gain_ff;

endmodule

@@ hw/rtl/ptpm_ctrl.sv @@
// Controller state machine that sequences measurement, division and result delivery.
`timescale 1ns / 1ps

module ptpm_ctrl
   import ptpm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_command,
   output logic            req_ready,
   input  ptpm_status_type status,
   output ptpm_cmd_type    cmd
);

   localparam logic [2:0] ST_WAIT_FIRST  = 3'd0;
   localparam logic [2:0] ST_WAIT_LEAVE  = 3'd1;
   localparam logic [2:0] ST_WAIT_SECOND = 3'd2;
   localparam logic [2:0] ST_WAIT_TEST   = 3'd3;
   localparam logic [2:0] ST_IDLE        = 3'd4;
   localparam logic [2:0] ST_DIVIDE      = 3'd5;
   localparam logic [2:0] ST_MULTIPLY    = 3'd6;
   localparam logic [2:0] ST_DELIVER     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_WAIT_FIRST) || (state_ff == ST_WAIT_LEAVE) ||
                      (state_ff == ST_WAIT_SECOND) || (state_ff == ST_WAIT_TEST) ||
                      (state_ff == ST_IDLE);
   assign accept = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_WAIT_FIRST, ST_WAIT_LEAVE, ST_WAIT_SECOND, ST_WAIT_TEST, ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_REARM) begin
                  cmd.rearm = 1'b1;
                  state_in  = ST_WAIT_FIRST;
               end else begin
                  unique case (state_ff)
                     ST_WAIT_FIRST: begin
                        if (status.ref_peak) begin
                           cmd.first_peak = 1'b1;
                           state_in       = ST_WAIT_LEAVE;
                        end
                     end
                     ST_WAIT_LEAVE: begin
                        cmd.count = 1'b1;
                        if (!status.ref_peak) begin
                           state_in = ST_WAIT_SECOND;
                        end
                     end
                     ST_WAIT_SECOND: begin
                        cmd.count = 1'b1;
                        if (status.ref_peak) begin
                           cmd.latch_period = 1'b1;
                           if (status.tst_peak) begin
                              cmd.launch = 1'b1;
                              state_in   = ST_DIVIDE;
                           end else begin
                              state_in = ST_WAIT_TEST;
                           end
                        end
                     end
                     ST_WAIT_TEST: begin
                        cmd.count = 1'b1;
                        if (status.tst_peak) begin
                           cmd.launch = 1'b1;
                           state_in   = ST_DIVIDE;
                        end
                     end
                     default: state_in = state_ff;
                  endcase
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT_FIRST;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ptpm_datapath.sv @@
// Datapath with tick counters, serial divider, gain multiplier and result register.
`timescale 1ns / 1ps

module ptpm_datapath
   import ptpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [LEVEL_W-1:0] sample_ref,
   input  logic [LEVEL_W-1:0] sample_test,
   input  logic [LEVEL_W-1:0] peak_level,
   input  logic [GAIN_W-1:0]  correction_gain,
   input  ptpm_cmd_type       cmd,
   output ptpm_status_type    status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [PHASE_W-1:0] phase_degrees,
   output logic [TICKS_W-1:0] period_ticks,
   output logic [TICKS_W-1:0] delay_ticks,
   output logic [ERR_W-1:0]   error_code
);

   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic                   sat_ff, sat_in;
   logic [COUNT_WIDTH-1:0] tick_inc;
   logic                   sat_inc;
   logic [COUNT_WIDTH-1:0] period_src;
   logic [COUNT_WIDTH-1:0] delay_src;

   logic [DIV_W-1:0]       dq_ff;
   logic [COUNT_WIDTH:0]   rem_ff;
   logic [COUNT_WIDTH-1:0] divisor_ff;
   logic [STEP_W-1:0]      step_ff;
   logic                   pzero_ff;
   logic                   csat_ff;
   logic [TICKS_W-1:0]     per_clip_ff;
   logic [TICKS_W-1:0]     dly_clip_ff;
   logic [PROD_W-1:0]      prod_ff;

   logic [COUNT_WIDTH:0]   rem_sh;
   logic [COUNT_WIDTH+1:0] rem_diff;
   logic                   q_bit;
   logic [BASE_W-1:0]      base_c;
   logic [PROD_W-1:0]      scaled;
   logic [PHASE_W-1:0]     phase_c;

   logic                   out_valid_ff;
   logic [PHASE_W-1:0]     out_phase_ff;
   logic [TICKS_W-1:0]     out_period_ff;
   logic [TICKS_W-1:0]     out_delay_ff;
   logic [ERR_W-1:0]       out_err_ff;

   assign tick_inc = (tick_ff != {COUNT_WIDTH{1'b1}}) ? tick_ff + 1'b1 : tick_ff;
   assign sat_inc  = sat_ff | (tick_inc == {COUNT_WIDTH{1'b1}});

   assign period_src = cmd.latch_period ? tick_inc : period_ff;
   assign delay_src  = cmd.latch_period ? '0 : tick_inc;

   always_comb begin
      tick_in   = tick_ff;
      period_in = period_ff;
      sat_in    = sat_ff;
      priority if (cmd.rearm) begin
         tick_in   = '0;
         period_in = '0;
         sat_in    = 1'b0;
      end else if (cmd.first_peak) begin
         tick_in = '0;
         sat_in  = 1'b0;
      end else if (cmd.latch_period) begin
         tick_in   = '0;
         period_in = tick_inc;
         sat_in    = sat_inc;
      end else if (cmd.count) begin
         tick_in = tick_inc;
         sat_in  = sat_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         period_ff <= '0;
         sat_ff    <= 1'b0;
      end else begin
         tick_ff   <= tick_in;
         period_ff <= period_in;
         sat_ff    <= sat_in;
      end
   end

   assign rem_sh   = {rem_ff[COUNT_WIDTH-1:0], dq_ff[DIV_W-1]};
   assign rem_diff = {1'b0, rem_sh} - {2'b00, divisor_ff};
   assign q_bit    = ~rem_diff[COUNT_WIDTH+1];

   assign base_c = (64'(dq_ff) >= 64'(BASE_LIMIT)) ? BASE_W'(BASE_LIMIT) : BASE_W'(dq_ff);
   assign scaled = prod_ff >> GAIN_SHIFT;
   assign phase_c = pzero_ff ? '0 :
                    (scaled > PROD_W'(PHASE_MAX)) ? PHASE_W'(PHASE_MAX) : scaled[PHASE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.launch) begin
         dq_ff       <= DIV_W'(delay_src) * DIV_W'(DEG_FULL);
         rem_ff      <= '0;
         divisor_ff  <= period_src;
         step_ff     <= '0;
         pzero_ff    <= (period_src == '0);
         csat_ff     <= sat_inc;
         per_clip_ff <= clip_ticks(period_src);
         dly_clip_ff <= clip_ticks(delay_src);
      end else if (cmd.div_step) begin
         dq_ff   <= {dq_ff[DIV_W-2:0], q_bit};
         rem_ff  <= q_bit ? rem_diff[COUNT_WIDTH:0] : rem_sh;
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.multiply) begin
         prod_ff <= PROD_W'(base_c) * PROD_W'(correction_gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_phase_ff  <= phase_c;
         out_period_ff <= per_clip_ff;
         out_delay_ff  <= dly_clip_ff;
         out_err_ff    <= pzero_ff ? ERR_PERIOD_ZERO : (csat_ff ? ERR_SATURATED : ERR_OK);
      end
   end

   assign status.ref_peak = (sample_ref == peak_level);
   assign status.tst_peak = (sample_test == peak_level);
   assign status.div_last = (step_ff == STEP_W'(DIV_W - 1));
   assign status.out_free = ~out_valid_ff | rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign phase_degrees = out_phase_ff;
   assign period_ticks  = out_period_ff;
   assign delay_ticks   = out_delay_ff;
   assign error_code    = out_err_ff;

endmodule

@@ hw/rtl/ptpm_checker.sv @@
// Port-level assertion checker for the phase meter and its bind to the top level.
`timescale 1ns / 1ps

module ptpm_sva_checker
   import ptpm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PHASE_W-1:0] phase_degrees,
   input logic [TICKS_W-1:0] period_ticks,
   input logic [ERR_W-1:0]   error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(phase_degrees) &&
      $stable(period_ticks) && $stable(error_code))
      else $error("Response beat changed while stalled.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response beat present right after reset.");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> error_code == ERR_OK || error_code == ERR_PERIOD_ZERO ||
      error_code == ERR_SATURATED)
      else $error("Response beat carries an undefined error code.");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code == ERR_PERIOD_ZERO |-> phase_degrees == '0 &&
      period_ticks == '0)
      else $error("Period-zero response has nonzero phase or period.");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != ERR_PERIOD_ZERO |-> period_ticks != '0)
      else $error("Response with zero period lacks the period-zero code.");

endmodule

bind peak_timing_phase_meter_top ptpm_sva_checker u_ptpm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .phase_degrees (rsp_bus.phase_degrees),
   .period_ticks  (rsp_bus.period_ticks),
   .error_code    (rsp_bus.error_code)
);
